/* sv/gmb_pkg.sv */
// ----------------------------------------------------------------------------
// gmb_pkg - shared definitions for the grid maze backtracker step unit
// Grid limits, cell index layout, codes, and the controller/datapath structs.
// ----------------------------------------------------------------------------
package gmb_pkg;

  // Grid limits and cell index layout: index = {y, x}
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int X_BITS     = $clog2(MAX_WIDTH);
  localparam int Y_BITS     = $clog2(MAX_HEIGHT);
  localparam int CELL_BITS  = X_BITS + Y_BITS;
  localparam int CELL_DEPTH = 1 << CELL_BITS;
  localparam int ROW_STEP   = 1 << X_BITS;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int STACK_BITS = $clog2(CELL_COUNT);
  localparam int COUNT_BITS = $clog2(CELL_COUNT + 1);

  // Field widths
  localparam int SIZE_BITS  = 7;
  localparam int COORD_BITS = 6;
  localparam int RND_BITS   = 32;
  localparam int CFG_IDX_BITS = 1;
  // Width for bound compares: holds any size limit plus one
  localparam int DIM_BITS   = 10;

  // Reciprocal of 3 for x mod 3 on 32-bit x: q = (x * RECIP3) >> 33
  localparam logic [RND_BITS-1:0] RECIP3 = 32'hAAAA_AAAB;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [SIZE_BITS-1:0] GRID_WIDTH_RESET  = 7'd16;
  localparam logic [SIZE_BITS-1:0] GRID_HEIGHT_RESET = 7'd16;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ACT_MOVED       = 2'd0,
    ACT_BACKTRACKED = 2'd1,
    ACT_FINISHED    = 2'd2,
    ACT_RESTARTED   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP,
    ST_MARK,
    ST_RD_E,
    ST_RD_S,
    ST_RD_W,
    ST_DECIDE,
    ST_EMPTY,
    ST_RESTART,
    ST_CLEAR
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic take;         // latch the random value of the accepted word
    logic stack_rd;     // read the stack top
    logic mark;         // mark the current cell visited
    logic vis_rd;       // read a neighbor's visited bit
    dir_t rd_dir;       // neighbor being read
    logic cap;          // capture the visited bit read last cycle
    dir_t cap_dir;      // neighbor it belongs to
    logic decide;       // pop or push, load a move/backtrack result
    logic ld_finished;  // load the empty-stack result
    logic ld_restart;   // load the restart result, reset the stack
    logic clr_en;       // clear one visited entry
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic stack_empty;
    logic out_free;
    logic clr_done;
  } stat_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
    action_t               action;
    dir_t                  wall_direction;
    logic                  random_used;
    logic                  more_work;
  } result_t;

endpackage

/* sv/gmb_if.sv */
// ----------------------------------------------------------------------------
// gmb_if - channel interfaces of the grid maze backtracker step unit
// Input items, result items and configuration writes, each valid/ready.
// ----------------------------------------------------------------------------

// Input item channel
interface gmb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [gmb_pkg::RND_BITS-1:0] random_value;

  modport source (output valid, kind, random_value, input ready);
  modport sink   (input valid, kind, random_value, output ready);
endinterface

// Result item channel
interface gmb_out_if;
  logic                          valid;
  logic                          ready;
  logic [gmb_pkg::COORD_BITS-1:0] cell_x;
  logic [gmb_pkg::COORD_BITS-1:0] cell_y;
  logic [1:0]                    action;
  logic [1:0]                    wall_direction;
  logic                          random_used;
  logic                          more_work;

  modport source (output valid, cell_x, cell_y, action, wall_direction, random_used,
                  more_work, input ready);
  modport sink   (input valid, cell_x, cell_y, action, wall_direction, random_used,
                  more_work, output ready);
endinterface

// Configuration write channel
interface gmb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gmb_pkg::CFG_IDX_BITS-1:0] index;
  logic [gmb_pkg::SIZE_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/gmb_ram.sv */
// ----------------------------------------------------------------------------
// gmb_ram - generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module gmb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/gmb_ctrl.sv */
// ----------------------------------------------------------------------------
// gmb_ctrl - step sequencer of the grid maze backtracker
// Walks a step through stack read, mark, four neighbor reads and decision;
// runs the visited-map clearing pass after reset and restart.
// ----------------------------------------------------------------------------
module gmb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            item_kind,
  output logic            item_ready,
  input  gmb_pkg::stat_t  stat,
  output gmb_pkg::cmd_t   cmd
);

  gmb_pkg::state_t state, state_next;

  // State register; reset starts with the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      gmb_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item_kind) begin
            state_next = gmb_pkg::ST_RESTART;
          end else if (stat.stack_empty) begin
            state_next = gmb_pkg::ST_EMPTY;
          end else begin
            state_next = gmb_pkg::ST_TOP;
          end
        end
      end
      gmb_pkg::ST_TOP:  state_next = gmb_pkg::ST_MARK;
      gmb_pkg::ST_MARK: state_next = gmb_pkg::ST_RD_E;
      gmb_pkg::ST_RD_E: state_next = gmb_pkg::ST_RD_S;
      gmb_pkg::ST_RD_S: state_next = gmb_pkg::ST_RD_W;
      gmb_pkg::ST_RD_W: state_next = gmb_pkg::ST_DECIDE;
      gmb_pkg::ST_DECIDE, gmb_pkg::ST_EMPTY: begin
        if (stat.out_free) begin
          state_next = gmb_pkg::ST_IDLE;
        end
      end
      gmb_pkg::ST_RESTART: begin
        if (stat.out_free) begin
          state_next = gmb_pkg::ST_CLEAR;
        end
      end
      gmb_pkg::ST_CLEAR: begin
        if (stat.clr_done) begin
          state_next = gmb_pkg::ST_IDLE;
        end
      end
      default: state_next = gmb_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    cmd.rd_dir  = gmb_pkg::DIR_NORTH;
    cmd.cap_dir = gmb_pkg::DIR_NORTH;
    item_ready  = 1'b0;
    case (state)
      gmb_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.take   = item_valid;
      end
      gmb_pkg::ST_TOP: begin
        cmd.stack_rd = 1'b1;
      end
      gmb_pkg::ST_MARK: begin
        cmd.mark   = 1'b1;
        cmd.vis_rd = 1'b1;
        cmd.rd_dir = gmb_pkg::DIR_NORTH;
      end
      gmb_pkg::ST_RD_E: begin
        cmd.vis_rd  = 1'b1;
        cmd.rd_dir  = gmb_pkg::DIR_EAST;
        cmd.cap     = 1'b1;
        cmd.cap_dir = gmb_pkg::DIR_NORTH;
      end
      gmb_pkg::ST_RD_S: begin
        cmd.vis_rd  = 1'b1;
        cmd.rd_dir  = gmb_pkg::DIR_SOUTH;
        cmd.cap     = 1'b1;
        cmd.cap_dir = gmb_pkg::DIR_EAST;
      end
      gmb_pkg::ST_RD_W: begin
        cmd.vis_rd  = 1'b1;
        cmd.rd_dir  = gmb_pkg::DIR_WEST;
        cmd.cap     = 1'b1;
        cmd.cap_dir = gmb_pkg::DIR_SOUTH;
      end
      gmb_pkg::ST_DECIDE: begin
        cmd.decide = stat.out_free;
      end
      gmb_pkg::ST_EMPTY: begin
        cmd.ld_finished = stat.out_free;
      end
      gmb_pkg::ST_RESTART: begin
        cmd.ld_restart = stat.out_free;
      end
      gmb_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/gmb_dpath.sv */
// ----------------------------------------------------------------------------
// gmb_dpath - datapath of the grid maze backtracker
// Grid size registers, path stack and visited map memories, neighbor
// bounds and choice logic, mod-3 unit and the result register.
// ----------------------------------------------------------------------------
module gmb_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  gmb_pkg::cmd_t                 cmd,
  output gmb_pkg::stat_t                stat,
  input  logic [gmb_pkg::RND_BITS-1:0]  random_value,
  gmb_cfg_if.sink                       cfg,
  gmb_out_if.source                     result
);

  logic [gmb_pkg::SIZE_BITS-1:0]  grid_width;
  logic [gmb_pkg::SIZE_BITS-1:0]  grid_height;
  logic [gmb_pkg::COUNT_BITS-1:0] stack_count;
  logic [gmb_pkg::COUNT_BITS-1:0] stack_top_idx;
  logic [gmb_pkg::CELL_BITS-1:0]  clr_addr;

  logic [gmb_pkg::RND_BITS-1:0]   rnd;
  logic [2*gmb_pkg::RND_BITS-1:0] prod;
  logic [gmb_pkg::RND_BITS-2:0]   quot;
  logic [gmb_pkg::RND_BITS-1:0]   quot3;
  logic [gmb_pkg::RND_BITS-1:0]   rem_wide;
  logic [1:0]                     mod3;

  logic [gmb_pkg::CELL_BITS-1:0]  stack_rdata;
  logic [gmb_pkg::CELL_BITS-1:0]  cur;
  logic [gmb_pkg::X_BITS-1:0]     cx;
  logic [gmb_pkg::Y_BITS-1:0]     cy;
  logic [gmb_pkg::DIM_BITS-1:0]   cx_d, cy_d, w_eff, h_eff;
  logic [gmb_pkg::CELL_BITS-1:0]  nb [4];

  logic                           vis_we;
  logic [gmb_pkg::CELL_BITS-1:0]  vis_waddr;
  logic [0:0]                     vis_wdata;
  logic [0:0]                     vis_rdata;
  logic [2:0]                     vis_cap;
  logic [3:0]                     in_grid;
  logic [3:0]                     open;
  logic [2:0]                     n_open;
  logic [1:0]                     pick;
  logic [2:0]                     seen;
  gmb_pkg::dir_t                  sel;
  logic                           push;

  gmb_pkg::result_t               res, res_next;
  logic                           res_valid;
  logic                           res_load;

  // Configuration writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gmb_pkg::GRID_WIDTH_RESET;
      grid_height <= gmb_pkg::GRID_HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        gmb_pkg::REG_GRID_WIDTH:  grid_width  <= cfg.data;
        gmb_pkg::REG_GRID_HEIGHT: grid_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Grid size in use: zero counts as one, clamp to the limit
  always_comb begin
    if (grid_width == '0) begin
      w_eff = gmb_pkg::DIM_BITS'(1);
    end else if (gmb_pkg::DIM_BITS'(grid_width) > gmb_pkg::DIM_BITS'(gmb_pkg::MAX_WIDTH)) begin
      w_eff = gmb_pkg::DIM_BITS'(gmb_pkg::MAX_WIDTH);
    end else begin
      w_eff = gmb_pkg::DIM_BITS'(grid_width);
    end
    if (grid_height == '0) begin
      h_eff = gmb_pkg::DIM_BITS'(1);
    end else if (gmb_pkg::DIM_BITS'(grid_height) >
                 gmb_pkg::DIM_BITS'(gmb_pkg::MAX_HEIGHT)) begin
      h_eff = gmb_pkg::DIM_BITS'(gmb_pkg::MAX_HEIGHT);
    end else begin
      h_eff = gmb_pkg::DIM_BITS'(grid_height);
    end
  end

  // Random word and random mod 3 by reciprocal multiply, two stages
  assign quot     = prod[2*gmb_pkg::RND_BITS-1:gmb_pkg::RND_BITS+1];
  assign quot3    = {quot, 1'b0} + {1'b0, quot};
  assign rem_wide = rnd - quot3;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rnd <= random_value;
    end
    prod <= rnd * gmb_pkg::RECIP3;
    mod3 <= rem_wide[1:0];
  end

  // Path stack: entry 0 is always the top-left cell, so it is never stored
  assign stack_top_idx = stack_count - gmb_pkg::COUNT_BITS'(1);

  gmb_ram #(
    .WIDTH (gmb_pkg::CELL_BITS),
    .DEPTH (gmb_pkg::CELL_COUNT)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (stack_count[gmb_pkg::STACK_BITS-1:0]),
    .wdata (nb[sel]),
    .re    (cmd.stack_rd),
    .raddr (stack_top_idx[gmb_pkg::STACK_BITS-1:0]),
    .rdata (stack_rdata)
  );

  assign cur  = (stack_count == gmb_pkg::COUNT_BITS'(1)) ? '0 : stack_rdata;
  assign cx   = cur[gmb_pkg::X_BITS-1:0];
  assign cy   = cur[gmb_pkg::CELL_BITS-1:gmb_pkg::X_BITS];
  assign cx_d = gmb_pkg::DIM_BITS'(cx);
  assign cy_d = gmb_pkg::DIM_BITS'(cy);

  // Neighbor cell indexes, up / right / down / left
  assign nb[gmb_pkg::DIR_NORTH] = cur - gmb_pkg::CELL_BITS'(gmb_pkg::ROW_STEP);
  assign nb[gmb_pkg::DIR_EAST]  = cur + gmb_pkg::CELL_BITS'(1);
  assign nb[gmb_pkg::DIR_SOUTH] = cur + gmb_pkg::CELL_BITS'(gmb_pkg::ROW_STEP);
  assign nb[gmb_pkg::DIR_WEST]  = cur - gmb_pkg::CELL_BITS'(1);

  // Visited map: mark or clear on the write port, neighbor on the read port
  assign vis_we    = cmd.mark | cmd.clr_en;
  assign vis_waddr = cmd.clr_en ? clr_addr : cur;
  assign vis_wdata = cmd.mark;

  gmb_ram #(
    .WIDTH (1),
    .DEPTH (gmb_pkg::CELL_DEPTH)
  ) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .re    (cmd.vis_rd),
    .raddr (nb[cmd.rd_dir]),
    .rdata (vis_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      vis_cap[cmd.cap_dir] <= vis_rdata[0];
    end
  end

  // Bounds first; a top cell left outside a shrunk grid has no neighbors there
  always_comb begin
    in_grid[gmb_pkg::DIR_NORTH] = (cy != '0) && (cy_d - gmb_pkg::DIM_BITS'(1) < h_eff) &&
                                  (cx_d < w_eff);
    in_grid[gmb_pkg::DIR_EAST]  = (cx_d + gmb_pkg::DIM_BITS'(1) < w_eff) && (cy_d < h_eff);
    in_grid[gmb_pkg::DIR_SOUTH] = (cy_d + gmb_pkg::DIM_BITS'(1) < h_eff) && (cx_d < w_eff);
    in_grid[gmb_pkg::DIR_WEST]  = (cx != '0) && (cx_d - gmb_pkg::DIM_BITS'(1) < w_eff) &&
                                  (cy_d < h_eff);
  end

  assign open   = in_grid & ~{vis_rdata[0], vis_cap};
  assign n_open = 3'($countones(open));

  // Choice index: single neighbor needs no randomness
  always_comb begin
    case (n_open)
      3'd2:    pick = {1'b0, rnd[0]};
      3'd3:    pick = mod3;
      3'd4:    pick = rnd[1:0];
      default: pick = 2'd0;
    endcase
  end

  // Direction of the pick-th open neighbor
  always_comb begin
    sel  = gmb_pkg::DIR_NORTH;
    seen = '0;
    for (int j = 0; j < 4; j++) begin
      if (open[j]) begin
        if (seen == {1'b0, pick}) begin
          sel = gmb_pkg::dir_t'(2'(j));
        end
        seen = seen + 3'd1;
      end
    end
  end

  assign push = cmd.decide && (n_open != '0) &&
                (stack_count < gmb_pkg::COUNT_BITS'(gmb_pkg::CELL_COUNT));

  // Stack depth and clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= gmb_pkg::COUNT_BITS'(1);
      clr_addr    <= '0;
    end else begin
      if (cmd.ld_restart) begin
        stack_count <= gmb_pkg::COUNT_BITS'(1);
      end else if (cmd.decide && (n_open == '0)) begin
        stack_count <= stack_top_idx;
      end else if (push) begin
        stack_count <= stack_count + gmb_pkg::COUNT_BITS'(1);
      end
      if (cmd.clr_en) begin
        clr_addr <= clr_addr + gmb_pkg::CELL_BITS'(1);
      end
    end
  end

  // Result word
  always_comb begin
    res_next                = '0;
    res_next.action         = gmb_pkg::ACT_MOVED;
    res_next.wall_direction = gmb_pkg::DIR_NORTH;
    if (cmd.ld_restart) begin
      res_next.action    = gmb_pkg::ACT_RESTARTED;
      res_next.more_work = 1'b1;
    end else if (cmd.ld_finished) begin
      res_next.action    = gmb_pkg::ACT_FINISHED;
    end else begin
      res_next.cell_x = gmb_pkg::COORD_BITS'(cx);
      res_next.cell_y = gmb_pkg::COORD_BITS'(cy);
      if (n_open == '0) begin
        res_next.action    = gmb_pkg::ACT_BACKTRACKED;
        res_next.more_work = (stack_count != gmb_pkg::COUNT_BITS'(1));
      end else begin
        res_next.action         = gmb_pkg::ACT_MOVED;
        res_next.wall_direction = sel;
        res_next.random_used    = (n_open >= 3'd2);
        res_next.more_work      = 1'b1;
      end
    end
  end

  assign res_load = cmd.decide | cmd.ld_finished | cmd.ld_restart;

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid          = res_valid;
  assign result.cell_x         = res.cell_x;
  assign result.cell_y         = res.cell_y;
  assign result.action         = res.action;
  assign result.wall_direction = res.wall_direction;
  assign result.random_used    = res.random_used;
  assign result.more_work      = res.more_work;

  // Status
  assign stat.stack_empty = (stack_count == '0);
  assign stat.out_free    = !res_valid || result.ready;
  assign stat.clr_done    = &clr_addr;

endmodule

/* sv/grid_maze_backtracker_step_unit.sv */
// ----------------------------------------------------------------------------
// grid_maze_backtracker_step_unit - one depth-first maze walk step per item
// Step word: stack read, mark and four neighbor reads, then the decision; the
//   neighbor reads go one after another through the single read port of the visited map.
// Empty-stack step: finished result with no memory reads. Restart: result,
//   then a visited-map clearing pass before the next word.
// Reset (rst, synchronous): grid 16 x 16, stack holds the top-left cell, and
//   the same clearing pass runs; configuration writes always taken.
// ----------------------------------------------------------------------------
module grid_maze_backtracker_step_unit (
  input  logic        clk,
  input  logic        rst,
  gmb_in_if.sink      item,
  gmb_out_if.source   result,
  gmb_cfg_if.sink     cfg
);

  gmb_pkg::cmd_t  cmd;
  gmb_pkg::stat_t stat;

  // Sequencer
  gmb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_kind  (item.kind),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath
  gmb_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .random_value (item.random_value),
    .cfg          (cfg),
    .result       (result)
  );

  // One word at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("input accepted on consecutive cycles");

  // A finished walk reports no further work and no random use
  a_finished_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.action == gmb_pkg::ACT_FINISHED)) |->
      (!result.more_work && !result.random_used))
    else $error("finished result with work or random use");

  // Randomness is only consumed by a move
  a_random_on_move: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.random_used) |-> (result.action == gmb_pkg::ACT_MOVED))
    else $error("random value used without a move");

  // A move or restart always leaves work on the stack
  a_move_more: assert property (@(posedge clk) disable iff (rst)
    (result.valid && ((result.action == gmb_pkg::ACT_MOVED) ||
                      (result.action == gmb_pkg::ACT_RESTARTED))) |-> result.more_work)
    else $error("move or restart without remaining work");

endmodule
